[src/esk_pkg.sv]
// Shared types, codes and tables for the escape sequence key decoder.
`default_nettype none

package esk_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int TIMEOUT_W          = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd50;
  localparam int QUEUE_DEPTH        = 2;

  // received byte values of interest
  localparam logic [7:0] BYTE_BS     = 8'd8;
  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_DEL    = 8'd127;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SS3    = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] BYTE_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] BYTE_NINE   = 8'h39;  // '9'
  localparam logic [7:0] BYTE_A      = 8'h41;
  localparam logic [7:0] BYTE_B      = 8'h42;
  localparam logic [7:0] BYTE_C      = 8'h43;
  localparam logic [7:0] BYTE_D      = 8'h44;
  localparam logic [7:0] BYTE_F      = 8'h46;
  localparam logic [7:0] BYTE_H      = 8'h48;

  // special key codes
  localparam logic [7:0] KC_ESC     = 8'd0;
  localparam logic [7:0] KC_UP      = 8'd1;
  localparam logic [7:0] KC_DOWN    = 8'd2;
  localparam logic [7:0] KC_RIGHT   = 8'd3;
  localparam logic [7:0] KC_LEFT    = 8'd4;
  localparam logic [7:0] KC_HOME    = 8'd5;
  localparam logic [7:0] KC_END     = 8'd6;
  localparam logic [7:0] KC_INS     = 8'd7;
  localparam logic [7:0] KC_DEL     = 8'd8;
  localparam logic [7:0] KC_PGUP    = 8'd9;
  localparam logic [7:0] KC_PGDN    = 8'd10;
  localparam logic [7:0] KC_BKSP    = 8'd11;
  localparam logic [7:0] KC_UNKNOWN = 8'd12;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CSI,
    MODE_SS3,
    MODE_DIGITS
  } mode_t;

  typedef enum logic [3:0] {
    CLS_TICK,
    CLS_ESC,
    CLS_LBRACK,
    CLS_SS3,
    CLS_TILDE,
    CLS_DIGIT,
    CLS_LETTER,
    CLS_BKSP,
    CLS_OTHER
  } cls_t;

  // classified beat as held in the queue
  typedef struct packed {
    cls_t       cls;
    logic [3:0] sub;   // digit value or cursor key code
    logic [7:0] data;
  } item_t;

  // key for ESC [ n ~
  function automatic logic [7:0] tilde_key(input logic [3:0] n);
    logic [7:0] k;
    case (n)
      4'd1:    k = KC_HOME;
      4'd2:    k = KC_INS;
      4'd3:    k = KC_DEL;
      4'd4:    k = KC_END;
      4'd5:    k = KC_PGUP;
      4'd6:    k = KC_PGDN;
      4'd7:    k = KC_HOME;
      4'd8:    k = KC_END;
      default: k = KC_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[src/esk_in_if.sv]
// Input channel: received bytes and time ticks.
`default_nettype none

interface esk_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

[src/esk_out_if.sv]
// Result channel: decoded key events.
`default_nettype none

interface esk_out_if;
  logic       valid;
  logic       ready;
  logic       is_special;
  logic [7:0] key_value;

  modport source (output valid, output is_special, output key_value, input ready);
  modport sink   (input valid, input is_special, input key_value, output ready);
endinterface

`default_nettype wire

[src/escape_sequence_key_decoder_top.sv]
// Top level of the terminal escape sequence key decoder.
`default_nettype none

// Channel    Dir  Payload                          Handshake
// in_beat    in   command, data_byte[7:0]          valid/ready
// out_beat   out  is_special, key_value[7:0]       valid/ready
// cfg        in   cfg_wdata[15:0] (timeout ticks)  cfg_we, no wait
//
// One beat per cycle sustained while out_beat is not stalled. A beat is
// classified into the two-entry queue, then popped by the sequence state
// machine, which updates mode, digit value and tick counter as it pops.
// A key event appears on out_beat the cycle after its beat leaves the queue.
// Reset (rst_n low, synchronous) clears mode, counter, queue and sets the
// timeout to 50 ticks. A stalled out_beat holds the result register; the
// queue absorbs up to two more beats before in_beat.ready drops.

module escape_sequence_key_decoder_top #(
  parameter int TIMER_BITS = esk_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  esk_in_if.sink                             in_beat,
  esk_out_if.source                          out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [esk_pkg::TIMEOUT_W-1:0] cfg_wdata
);

  logic [esk_pkg::TIMEOUT_W-1:0] timeout_r, timeout_nxt;

  esk_pkg::item_t push_item;
  esk_pkg::item_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;

  // timeout register: taken whenever write enable is high
  assign timeout_nxt = cfg_we ? cfg_wdata : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= esk_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // classify incoming beats: tick, ESC, '[', 'O', '~', digit, cursor letter, backspace, other
  esk_front u_front (
    .in_beat   (in_beat),
    .q_full    (q_full),
    .push_item (push_item),
    .push      (push)
  );

  // decouples input acceptance from output stalls
  esk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // sequence decoding, timeout and result register
  esk_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_timeout (timeout_r),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_beat    (out_beat)
  );

endmodule

`default_nettype wire

[src/esk_front.sv]
// Front end: accepts input beats and classifies them for the queue.
`default_nettype none

module esk_front (
  esk_in_if.sink         in_beat,
  input  wire logic      q_full,
  output esk_pkg::item_t push_item,
  output logic           push
);

  assign in_beat.ready = !q_full;
  assign push          = in_beat.valid && !q_full;

  always_comb begin
    push_item.data = in_beat.data_byte;
    push_item.sub  = in_beat.data_byte[3:0];
    push_item.cls  = esk_pkg::CLS_OTHER;
    if (in_beat.command == esk_pkg::CMD_TICK) begin
      push_item.cls = esk_pkg::CLS_TICK;
    end else if (in_beat.data_byte == esk_pkg::BYTE_ESC) begin
      push_item.cls = esk_pkg::CLS_ESC;
    end else if (in_beat.data_byte == esk_pkg::BYTE_LBRACK) begin
      push_item.cls = esk_pkg::CLS_LBRACK;
    end else if (in_beat.data_byte == esk_pkg::BYTE_SS3) begin
      push_item.cls = esk_pkg::CLS_SS3;
    end else if (in_beat.data_byte == esk_pkg::BYTE_TILDE) begin
      push_item.cls = esk_pkg::CLS_TILDE;
    end else if (in_beat.data_byte inside {[esk_pkg::BYTE_ZERO:esk_pkg::BYTE_NINE]}) begin
      push_item.cls = esk_pkg::CLS_DIGIT;
    end else if (in_beat.data_byte inside {esk_pkg::BYTE_BS, esk_pkg::BYTE_DEL}) begin
      push_item.cls = esk_pkg::CLS_BKSP;
    end else begin
      case (in_beat.data_byte)
        esk_pkg::BYTE_A: begin
          push_item.cls = esk_pkg::CLS_LETTER;
          push_item.sub = esk_pkg::KC_UP[3:0];
        end
        esk_pkg::BYTE_B: begin
          push_item.cls = esk_pkg::CLS_LETTER;
          push_item.sub = esk_pkg::KC_DOWN[3:0];
        end
        esk_pkg::BYTE_C: begin
          push_item.cls = esk_pkg::CLS_LETTER;
          push_item.sub = esk_pkg::KC_RIGHT[3:0];
        end
        esk_pkg::BYTE_D: begin
          push_item.cls = esk_pkg::CLS_LETTER;
          push_item.sub = esk_pkg::KC_LEFT[3:0];
        end
        esk_pkg::BYTE_H: begin
          push_item.cls = esk_pkg::CLS_LETTER;
          push_item.sub = esk_pkg::KC_HOME[3:0];
        end
        esk_pkg::BYTE_F: begin
          push_item.cls = esk_pkg::CLS_LETTER;
          push_item.sub = esk_pkg::KC_END[3:0];
        end
        default: push_item.cls = esk_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/esk_queue.sv]
// Small FIFO of classified beats between front and back.
`default_nettype none

module esk_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire esk_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output esk_pkg::item_t      head
);

  localparam int Depth = esk_pkg::QUEUE_DEPTH;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  esk_pkg::item_t mem [Depth];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full      = (count_r == CW'(Depth));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[src/esk_back.sv]
// Back end: sequence state machine, tick timer and result register.
`default_nettype none

module esk_back #(
  parameter int TIMER_BITS = esk_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [esk_pkg::TIMEOUT_W-1:0] cfg_timeout,
  input  wire logic                          q_not_empty,
  input  wire esk_pkg::item_t                head,
  output logic                               pop,
  esk_out_if.source                          out_beat
);

  localparam int LW = (TIMER_BITS > esk_pkg::TIMEOUT_W) ? TIMER_BITS : esk_pkg::TIMEOUT_W;
  localparam logic [TIMER_BITS-1:0] CntMax = {TIMER_BITS{1'b1}};

  esk_pkg::mode_t mode_r, mode_nxt;
  logic [3:0]            seq_r, seq_nxt;
  logic [TIMER_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_special_r;
  logic [7:0]            out_key_r;

  logic                  emit;
  logic                  emit_special;
  logic [7:0]            emit_key;
  logic [TIMER_BITS-1:0] cnt_inc;
  logic [LW-1:0]         tmo_ext;
  logic [LW-1:0]         limit;
  logic                  timed_out;
  logic [7:0]            seq_mul;
  logic [3:0]            seq_acc;

  assign pop = q_not_empty && (!out_valid_r || out_beat.ready);

  // effective timeout: zero acts as one, clipped to the counter range
  assign tmo_ext   = LW'(cfg_timeout);
  assign cnt_inc   = (cnt_r == CntMax) ? cnt_r : cnt_r + 1'b1;
  assign timed_out = (LW'(cnt_inc) >= limit);

  always_comb begin
    if (tmo_ext == '0) begin
      limit = LW'(1);
    end else if (tmo_ext > LW'(CntMax)) begin
      limit = LW'(CntMax);
    end else begin
      limit = tmo_ext;
    end
  end

  // seq * 10 + digit, saturating at 15
  assign seq_mul = {1'b0, seq_r, 3'b000} + {3'b000, seq_r, 1'b0} + {4'h0, head.sub};
  assign seq_acc = (seq_mul > 8'd15) ? 4'd15 : seq_mul[3:0];

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (pop) begin
      case (mode_r)
        esk_pkg::MODE_IDLE: begin
          if (head.cls == esk_pkg::CLS_ESC) begin
            mode_nxt = esk_pkg::MODE_ESC;
          end
        end
        esk_pkg::MODE_ESC: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            mode_nxt = timed_out ? esk_pkg::MODE_IDLE : mode_r;
          end else if (head.cls == esk_pkg::CLS_LBRACK) begin
            mode_nxt = esk_pkg::MODE_CSI;
          end else if (head.cls == esk_pkg::CLS_SS3) begin
            mode_nxt = esk_pkg::MODE_SS3;
          end else begin
            mode_nxt = esk_pkg::MODE_IDLE;
          end
        end
        esk_pkg::MODE_CSI: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            mode_nxt = timed_out ? esk_pkg::MODE_IDLE : mode_r;
          end else if (head.cls == esk_pkg::CLS_DIGIT) begin
            mode_nxt = esk_pkg::MODE_DIGITS;
          end else begin
            mode_nxt = esk_pkg::MODE_IDLE;
          end
        end
        esk_pkg::MODE_SS3: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            mode_nxt = timed_out ? esk_pkg::MODE_IDLE : mode_r;
          end else begin
            mode_nxt = esk_pkg::MODE_IDLE;
          end
        end
        esk_pkg::MODE_DIGITS: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            mode_nxt = timed_out ? esk_pkg::MODE_IDLE : mode_r;
          end else if (head.cls != esk_pkg::CLS_DIGIT) begin
            mode_nxt = esk_pkg::MODE_IDLE;
          end
        end
        default: mode_nxt = esk_pkg::MODE_IDLE;
      endcase
    end
  end

  // results, digit value and timer
  always_comb begin
    emit         = 1'b0;
    emit_special = 1'b1;
    emit_key     = esk_pkg::KC_UNKNOWN;
    seq_nxt      = seq_r;
    cnt_nxt      = cnt_r;
    if (pop) begin
      case (mode_r)
        esk_pkg::MODE_IDLE: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            emit = 1'b0;
          end else if (head.cls == esk_pkg::CLS_ESC) begin
            seq_nxt = '0;
            cnt_nxt = '0;
          end else if (head.cls == esk_pkg::CLS_BKSP) begin
            emit     = 1'b1;
            emit_key = esk_pkg::KC_BKSP;
          end else begin
            emit         = 1'b1;
            emit_special = 1'b0;
            emit_key     = head.data;
          end
        end
        esk_pkg::MODE_ESC: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            cnt_nxt  = cnt_inc;
            emit     = timed_out;
            emit_key = esk_pkg::KC_ESC;
          end else if (head.cls == esk_pkg::CLS_LBRACK || head.cls == esk_pkg::CLS_SS3) begin
            cnt_nxt = '0;
          end else begin
            emit     = 1'b1;
            emit_key = esk_pkg::KC_ESC;
          end
        end
        esk_pkg::MODE_CSI: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            cnt_nxt  = cnt_inc;
            emit     = timed_out;
            emit_key = esk_pkg::KC_ESC;
          end else if (head.cls == esk_pkg::CLS_LETTER) begin
            emit     = 1'b1;
            emit_key = {4'h0, head.sub};
          end else if (head.cls == esk_pkg::CLS_DIGIT) begin
            seq_nxt = head.sub;
            cnt_nxt = '0;
          end else begin
            emit = 1'b1;
          end
        end
        esk_pkg::MODE_SS3: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            cnt_nxt  = cnt_inc;
            emit     = timed_out;
            emit_key = esk_pkg::KC_ESC;
          end else if (head.cls == esk_pkg::CLS_LETTER) begin
            emit     = 1'b1;
            emit_key = {4'h0, head.sub};
          end else begin
            emit = 1'b1;
          end
        end
        esk_pkg::MODE_DIGITS: begin
          if (head.cls == esk_pkg::CLS_TICK) begin
            cnt_nxt = cnt_inc;
            emit    = timed_out;
          end else if (head.cls == esk_pkg::CLS_DIGIT) begin
            seq_nxt = seq_acc;
            cnt_nxt = '0;
          end else if (head.cls == esk_pkg::CLS_TILDE) begin
            emit     = 1'b1;
            emit_key = esk_pkg::tilde_key(seq_r);
          end else begin
            emit = 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
      if (emit) begin
        seq_nxt = '0;
        cnt_nxt = '0;
      end
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_beat.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= esk_pkg::MODE_IDLE;
      seq_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      seq_r       <= seq_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_special_r <= emit_special;
      out_key_r     <= emit_key;
    end
  end

  assign out_beat.valid      = out_valid_r;
  assign out_beat.is_special = out_special_r;
  assign out_beat.key_value  = out_key_r;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the terminal escape sequence key decoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;     // beat through queue and state machine, with margin
  localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either channel

  typedef struct packed {
    logic       is_special;
    logic [7:0] key_value;
  } key_event_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  esk_in_if  in_ch ();
  esk_out_if out_ch ();

  escape_sequence_key_decoder_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Decoder state as the testbench sees it
  esk_pkg::mode_t dec_mode;
  logic [3:0]     dec_num;
  logic [15:0]    dec_wait;
  logic [15:0]    timeout_cfg;

  key_event_t  pending_keys[$];

  int stall_pct = 25;     // idle share of both channels, in percent
  int beats_sent = 0;
  int keys_seen = 0;
  int special_seen = 0;
  int timeouts_seen = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------

  // Cursor letter after ESC [ or ESC O
  function automatic bit cursor_key(input logic [7:0] b, output logic [7:0] k);
    k = esk_pkg::KC_UNKNOWN;
    case (b)
      esk_pkg::BYTE_A: k = esk_pkg::KC_UP;
      esk_pkg::BYTE_B: k = esk_pkg::KC_DOWN;
      esk_pkg::BYTE_C: k = esk_pkg::KC_RIGHT;
      esk_pkg::BYTE_D: k = esk_pkg::KC_LEFT;
      esk_pkg::BYTE_H: k = esk_pkg::KC_HOME;
      esk_pkg::BYTE_F: k = esk_pkg::KC_END;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advances the decoder state by one beat; returns 1 when a key comes out
  function automatic bit decode_key(input logic cmd, input logic [7:0] b,
                                    output logic sp, output logic [7:0] kv);
    logic [15:0] lim;
    logic [7:0]  cur;
    int          n;
    sp = 1'b1;
    kv = esk_pkg::KC_UNKNOWN;
    if (cmd == esk_pkg::CMD_TICK) begin
      if (dec_mode == esk_pkg::MODE_IDLE) return 1'b0;
      lim = (timeout_cfg == 16'd0) ? 16'd1 : timeout_cfg;
      if (dec_wait != 16'hFFFF) dec_wait++;
      if (dec_wait < lim) return 1'b0;
      kv = (dec_mode == esk_pkg::MODE_DIGITS) ? esk_pkg::KC_UNKNOWN : esk_pkg::KC_ESC;
      timeouts_seen++;
    end else begin
      case (dec_mode)
        esk_pkg::MODE_ESC: begin
          if (b == esk_pkg::BYTE_LBRACK) begin
            dec_mode = esk_pkg::MODE_CSI;
            dec_wait = '0;
            return 1'b0;
          end
          if (b == esk_pkg::BYTE_SS3) begin
            dec_mode = esk_pkg::MODE_SS3;
            dec_wait = '0;
            return 1'b0;
          end
          kv = esk_pkg::KC_ESC;
        end
        esk_pkg::MODE_CSI: begin
          if (cursor_key(b, cur)) begin
            kv = cur;
          end else if (b >= esk_pkg::BYTE_ZERO && b <= esk_pkg::BYTE_NINE) begin
            dec_mode = esk_pkg::MODE_DIGITS;
            dec_num  = 4'(b - esk_pkg::BYTE_ZERO);
            dec_wait = '0;
            return 1'b0;
          end
        end
        esk_pkg::MODE_SS3: begin
          if (cursor_key(b, cur)) kv = cur;
        end
        esk_pkg::MODE_DIGITS: begin
          if (b >= esk_pkg::BYTE_ZERO && b <= esk_pkg::BYTE_NINE) begin
            n = int'(dec_num) * 10 + int'(b - esk_pkg::BYTE_ZERO);
            dec_num  = (n > 15) ? 4'd15 : 4'(n);
            dec_wait = '0;
            return 1'b0;
          end
          if (b == esk_pkg::BYTE_TILDE) begin
            case (dec_num)
              4'd1, 4'd7: kv = esk_pkg::KC_HOME;
              4'd2:       kv = esk_pkg::KC_INS;
              4'd3:       kv = esk_pkg::KC_DEL;
              4'd4, 4'd8: kv = esk_pkg::KC_END;
              4'd5:       kv = esk_pkg::KC_PGUP;
              4'd6:       kv = esk_pkg::KC_PGDN;
              default:    kv = esk_pkg::KC_UNKNOWN;
            endcase
          end
        end
        default: begin
          if (b == esk_pkg::BYTE_ESC) begin
            dec_mode = esk_pkg::MODE_ESC;
            dec_num  = '0;
            dec_wait = '0;
            return 1'b0;
          end
          if (b == esk_pkg::BYTE_DEL || b == esk_pkg::BYTE_BS) begin
            kv = esk_pkg::KC_BKSP;
          end else begin
            sp = 1'b0;
            kv = b;
          end
        end
      endcase
    end
    dec_mode = esk_pkg::MODE_IDLE;
    dec_num  = '0;
    dec_wait = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random backpressure and the check of every key event
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_keys
    key_event_t want;
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      keys_seen++;
      if (out_ch.is_special) special_seen++;
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected key event is_special=%0d key_value=%0d",
                 $time, out_ch.is_special, out_ch.key_value);
        errors++;
      end else begin
        want = pending_keys.pop_front();
        if (out_ch.is_special !== want.is_special) begin
          $display("%0t: is_special expected %0d actual %0d",
                   $time, want.is_special, out_ch.is_special);
          errors++;
        end
        if (out_ch.key_value !== want.key_value) begin
          $display("%0t: key_value expected %0d actual %0d",
                   $time, want.key_value, out_ch.key_value);
          errors++;
        end
      end
    end
  end

  // Watchdog: a correct run never goes this long without a beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, %0d key events still expected",
               $time, pending_keys.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // One beat on the input channel, with random idle cycles ahead of it.
  // valid stays high on return; a drain, or an idle cycle of the next call, lowers it.
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    logic       sp;
    logic [7:0] kv;
    while ($urandom_range(99) < stall_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (decode_key(cmd, b, sp, kv)) pending_keys.push_back('{sp, kv});
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(esk_pkg::CMD_BYTE, b);
  endtask

  // Ticks carry a random data byte, which the block must ignore
  task automatic send_ticks(input int count);
    repeat (count) send_beat(esk_pkg::CMD_TICK, 8'($urandom_range(255)));
  endtask

  // Wait until every expected key is out and the pipeline has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] ticks);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_cfg = ticks;
  endtask

  // Ticks between sequence bytes: mostly few, now and then up to one past the timeout, at most 60
  task automatic gap_ticks();
    int span;
    span = (int'(timeout_cfg) + 1 > 60) ? 60 : int'(timeout_cfg) + 1;
    if ($urandom_range(9) == 0)
      send_ticks($urandom_range(span));
    else
      send_ticks($urandom_range(2));
  endtask

  task automatic send_letter();
    case ($urandom_range(5))
      0: send_byte(esk_pkg::BYTE_A);
      1: send_byte(esk_pkg::BYTE_B);
      2: send_byte(esk_pkg::BYTE_C);
      3: send_byte(esk_pkg::BYTE_D);
      4: send_byte(esk_pkg::BYTE_H);
      default: send_byte(esk_pkg::BYTE_F);
    endcase
  endtask

  // One random key sequence; most are well formed, the rest noise or broken
  task automatic random_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      send_byte(esk_pkg::BYTE_ESC);
      gap_ticks();
      send_byte($urandom_range(1) ? esk_pkg::BYTE_LBRACK : esk_pkg::BYTE_SS3);
      gap_ticks();
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else send_letter();
    end else if (r < 60) begin
      send_byte(esk_pkg::BYTE_ESC);
      gap_ticks();
      send_byte(esk_pkg::BYTE_LBRACK);
      repeat ($urandom_range(1, 3)) begin
        gap_ticks();
        // digits 1..8 most of the time so that every tilde key shows up
        if ($urandom_range(3) == 0)
          send_byte(esk_pkg::BYTE_ZERO + 8'($urandom_range(9)));
        else
          send_byte(esk_pkg::BYTE_ZERO + 8'($urandom_range(1, 8)));
      end
      gap_ticks();
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(esk_pkg::BYTE_TILDE);
    end else if (r < 75) begin
      send_byte(8'($urandom_range(255)));
    end else if (r < 85) begin
      send_ticks($urandom_range(1, 3));
    end else if (r < 95) begin
      send_byte(esk_pkg::BYTE_ESC);
      gap_ticks();
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(esk_pkg::BYTE_ESC);
      send_byte(esk_pkg::BYTE_LBRACK);
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Tick while idle, byte extremes and both backspace codes
  task automatic test_plain_bytes();
    send_ticks(1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(esk_pkg::BYTE_DEL);
    send_byte(esk_pkg::BYTE_BS);
  endtask

  // Cursor key, lone escape, ESC [ ~ and a bad letter after ESC O
  task automatic test_escape_keys();
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_LBRACK); send_byte(esk_pkg::BYTE_A);
    send_byte(esk_pkg::BYTE_ESC); send_byte(8'h51);
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_LBRACK);
    send_byte(esk_pkg::BYTE_TILDE);
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_SS3); send_byte(8'h78);
  endtask

  // Digit value 17 saturates at 15 and ends as unknown
  task automatic test_digit_overflow();
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_LBRACK);
    send_byte(esk_pkg::BYTE_ZERO + 8'd1); send_byte(esk_pkg::BYTE_ZERO + 8'd7);
    send_byte(esk_pkg::BYTE_TILDE);
  endtask

  task automatic test_timeouts();
    // reset value of 50 ticks
    send_byte(esk_pkg::BYTE_ESC);
    send_ticks(50);
    // zero acts as one tick
    set_timeout(16'd0);
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_LBRACK);
    send_ticks(1);
    // bytes restart the count; then a timeout with digits pending
    set_timeout(16'd3);
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_LBRACK);
    send_ticks(2);
    send_byte(esk_pkg::BYTE_ZERO + 8'd4);
    send_ticks(2);
    send_byte(esk_pkg::BYTE_TILDE);
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_LBRACK);
    send_byte(esk_pkg::BYTE_ZERO + 8'd1);
    send_ticks(3);
    set_timeout(16'd1);
    send_byte(esk_pkg::BYTE_ESC); send_byte(esk_pkg::BYTE_SS3);
    send_ticks(1);
    // largest timeout: a long gap does not give up, the next byte ends it
    set_timeout(16'hFFFF);
    stall_pct = 0;
    send_byte(esk_pkg::BYTE_ESC);
    send_ticks(100);
    send_byte(8'h51);
    stall_pct = 25;
  endtask

  // Random sequences over several timeout settings, one phase with no idling
  task automatic test_random_sequences(input int total);
    logic [15:0] phase_timeout[4];
    int          target;
    phase_timeout = '{16'd3, 16'd1, 16'd50, 16'd7};
    for (int p = 0; p < 4; p++) begin
      set_timeout(phase_timeout[p]);
      stall_pct = (p == 2) ? 0 : 25;
      target = beats_sent + total / 4;
      while (beats_sent < target) random_sequence();
    end
    stall_pct = 25;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= esk_pkg::CMD_BYTE;
    in_ch.data_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    dec_mode    = esk_pkg::MODE_IDLE;
    dec_num     = '0;
    dec_wait    = '0;
    timeout_cfg = esk_pkg::TIMEOUT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_bytes();
    test_escape_keys();
    test_digit_overflow();
    test_timeouts();
    test_random_sequences(1000);

    drain();
    $display("Covered %0d input beats and %0d key events (%0d special, %0d by timeout)",
             beats_sent, keys_seen, special_seen, timeouts_seen);
    $display("with timeouts 0, 1, 3, 7, 50 and 65535 ticks; %0d mismatches", errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
